// File: src/rrpc_pkg.sv
// ----------------------------------------------------------------------------
// rrpc_pkg
// shared types and constants of the rounded-rectangle pixel coverage unit
// ----------------------------------------------------------------------------
package rrpc_pkg;

    localparam int MAX_DIM_DEF = 2048;

    localparam int DIM_W     = 12;
    localparam int OFF_W     = 11;
    localparam int RAD_W     = 11;
    localparam int COORD_W   = 13;
    localparam int ADDR_W    = 22;
    localparam int COLOR_W   = 32;
    localparam int SQ_W      = 2 * RAD_W;
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_RECT_X       = 3'd0,
        REG_RECT_Y       = 3'd1,
        REG_RECT_W       = 3'd2,
        REG_RECT_H       = 3'd3,
        REG_RADIUS       = 3'd4,
        REG_OUTLINE_MODE = 3'd5,
        REG_CANVAS_W     = 3'd6,
        REG_CANVAS_H     = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic signed [DIM_W-1:0] rect_x;
        logic signed [DIM_W-1:0] rect_y;
        logic [DIM_W-1:0]        rect_w;
        logic [DIM_W-1:0]        rect_h;
        logic [RAD_W-1:0]        radius;
        logic                    outline_mode;
        logic [DIM_W-1:0]        canvas_w;
        logic [DIM_W-1:0]        canvas_h;
    } cfg_t;

    typedef struct packed {
        logic                      pre_pass;
        logic                      corner;
        logic [RAD_W-1:0]          ax;
        logic [RAD_W-1:0]          ay;
        logic [RAD_W-1:0]          r;
        logic signed [COORD_W-1:0] xx;
        logic signed [COORD_W-1:0] yy;
        logic [DIM_W-1:0]          cw;
        logic [COLOR_W-1:0]        color;
    } geom_t;

    typedef struct packed {
        logic                      pre_pass;
        logic                      corner;
        logic [SQ_W-1:0]           dsq_x;
        logic [SQ_W-1:0]           dsq_y;
        logic [SQ_W-1:0]           rsq;
        logic [ADDR_W-1:0]         addr_prod;
        logic signed [COORD_W-1:0] xx;
        logic signed [COORD_W-1:0] yy;
        logic [COLOR_W-1:0]        color;
    } prod_t;

endpackage

// File: src/rrpc_geom.sv
// ----------------------------------------------------------------------------
// rrpc_geom
// clamps the radius, clips against rectangle and canvas, finds the corner
// quadrant and the distances to its circle centre, applies the outline ring test, registers the outcome
// ----------------------------------------------------------------------------
module rrpc_geom #(
    parameter int MAX_DIM = rrpc_pkg::MAX_DIM_DEF
) (
    input  logic                          clk,
    input  logic                          en,
    input  rrpc_pkg::cfg_t                cfg,
    input  logic [rrpc_pkg::OFF_W-1:0]    off_x,
    input  logic [rrpc_pkg::OFF_W-1:0]    off_y,
    input  logic [rrpc_pkg::COLOR_W-1:0]  color,
    output rrpc_pkg::geom_t               geom
);

    localparam int DW = rrpc_pkg::DIM_W;
    localparam int RW = rrpc_pkg::RAD_W;
    localparam int SAT_INT = (MAX_DIM > (2 ** DW) - 1) ? (2 ** DW) - 1 : MAX_DIM;
    localparam logic [DW-1:0] SAT_LIM = DW'(SAT_INT);

    rrpc_pkg::geom_t geom_reg;
    rrpc_pkg::geom_t geom_next;

    logic [DW-1:0]   w;
    logic [DW-1:0]   h;
    logic [DW-1:0]   cw;
    logic [DW-1:0]   ch;
    logic [RW-1:0]   r;
    logic [DW-1:0]   dx_e;
    logic [DW-1:0]   dy_e;
    logic [DW-1:0]   r_e;
    logic [DW-1:0]   w_r;
    logic [DW-1:0]   h_r;
    logic [DW-1:0]   ax_e;
    logic [DW-1:0]   ay_e;
    logic            left;
    logic            right;
    logic            top;
    logic            bottom;
    logic            in_rect;
    logic            on_canvas;
    logic            ring;
    logic signed [rrpc_pkg::COORD_W-1:0] xx;
    logic signed [rrpc_pkg::COORD_W-1:0] yy;

    function automatic logic [DW-1:0] sat_dim(input logic [DW-1:0] v);
        if (v > SAT_LIM)
        begin
            return SAT_LIM;
        end
        return v;
    endfunction

    always_comb
    begin
        w  = sat_dim(cfg.rect_w);
        h  = sat_dim(cfg.rect_h);
        cw = sat_dim(cfg.canvas_w);
        ch = sat_dim(cfg.canvas_h);

        // radius limited to half width, then half height
        r = cfg.radius;
        if (r > w[DW-1:1])
        begin
            r = w[DW-1:1];
        end
        if (r > h[DW-1:1])
        begin
            r = h[DW-1:1];
        end

        dx_e = {1'b0, off_x};
        dy_e = {1'b0, off_y};
        r_e  = {1'b0, r};
        w_r  = w - r_e;
        h_r  = h - r_e;

        xx = $signed({cfg.rect_x[DW-1], cfg.rect_x}) + $signed({2'b00, off_x});
        yy = $signed({cfg.rect_y[DW-1], cfg.rect_y}) + $signed({2'b00, off_y});

        in_rect   = (dx_e < w) && (dy_e < h);
        on_canvas = !xx[rrpc_pkg::COORD_W-1] && (xx[DW-1:0] < cw) &&
                    !yy[rrpc_pkg::COORD_W-1] && (yy[DW-1:0] < ch);

        left   = off_x < r;
        top    = off_y < r;
        right  = dx_e >= w_r;
        bottom = dy_e >= h_r;

        // distance from the circle centre one pixel inside the corner
        ax_e = left ? (r_e - DW'(1) - dx_e) : (dx_e - w_r);
        ay_e = top  ? (r_e - DW'(1) - dy_e) : (dy_e - h_r);

        ring = (dx_e == DW'(0)) || (dx_e == DW'(1)) ||
               (dx_e == w - DW'(1)) || (dx_e == w - DW'(2)) ||
               (dy_e == DW'(0)) || (dy_e == DW'(1)) ||
               (dy_e == h - DW'(1)) || (dy_e == h - DW'(2));

        geom_next.pre_pass = in_rect && on_canvas && (!cfg.outline_mode || ring);
        geom_next.corner   = (left || right) && (top || bottom);
        geom_next.ax       = ax_e[RW-1:0];
        geom_next.ay       = ay_e[RW-1:0];
        geom_next.r        = r;
        geom_next.xx       = xx;
        geom_next.yy       = yy;
        geom_next.cw       = cw;
        geom_next.color    = color;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            geom_reg <= geom_next;
        end
    end

    assign geom = geom_reg;

endmodule

// File: src/rrpc_prod.sv
// ----------------------------------------------------------------------------
// rrpc_prod
// squares of the corner distances and the radius, and the row offset of
// the pixel address, each product registered
// ----------------------------------------------------------------------------
module rrpc_prod (
    input  logic             clk,
    input  logic             en,
    input  rrpc_pkg::geom_t  geom,
    output rrpc_pkg::prod_t  prod
);

    localparam int RW = rrpc_pkg::RAD_W;
    localparam int SW = rrpc_pkg::SQ_W;
    localparam int AW = rrpc_pkg::ADDR_W;
    localparam int DW = rrpc_pkg::DIM_W;

    rrpc_pkg::prod_t prod_reg;
    rrpc_pkg::prod_t prod_next;

    always_comb
    begin
        prod_next.pre_pass  = geom.pre_pass;
        prod_next.corner    = geom.corner;
        prod_next.dsq_x     = {{(SW-RW){1'b0}}, geom.ax} * {{(SW-RW){1'b0}}, geom.ax};
        prod_next.dsq_y     = {{(SW-RW){1'b0}}, geom.ay} * {{(SW-RW){1'b0}}, geom.ay};
        prod_next.rsq       = {{(SW-RW){1'b0}}, geom.r} * {{(SW-RW){1'b0}}, geom.r};
        // low address bits only, wraps as the address does
        prod_next.addr_prod = {{(AW-DW){1'b0}}, geom.yy[DW-1:0]} *
                              {{(AW-DW){1'b0}}, geom.cw};
        prod_next.xx        = geom.xx;
        prod_next.yy        = geom.yy;
        prod_next.color     = geom.color;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

// File: src/rrpc_resolve.sv
// ----------------------------------------------------------------------------
// rrpc_resolve
// circle test, write enable and final address into the result register
// ----------------------------------------------------------------------------
module rrpc_resolve (
    input  logic                                clk,
    input  logic                                en,
    input  rrpc_pkg::prod_t                     prod,
    output logic                                write_enable,
    output logic signed [rrpc_pkg::COORD_W-1:0] canvas_x,
    output logic signed [rrpc_pkg::COORD_W-1:0] canvas_y,
    output logic [rrpc_pkg::ADDR_W-1:0]         pixel_address,
    output logic [rrpc_pkg::COLOR_W-1:0]        color_out
);

    localparam int SW = rrpc_pkg::SQ_W;
    localparam int AW = rrpc_pkg::ADDR_W;
    localparam int DW = rrpc_pkg::DIM_W;

    logic [SW:0]   dsum;
    logic          in_circle;
    logic          we_next;
    logic [AW-1:0] addr_next;

    logic                                we_reg;
    logic signed [rrpc_pkg::COORD_W-1:0] cx_reg;
    logic signed [rrpc_pkg::COORD_W-1:0] cy_reg;
    logic [AW-1:0]                       addr_reg;
    logic [rrpc_pkg::COLOR_W-1:0]        color_reg;

    always_comb
    begin
        dsum      = {1'b0, prod.dsq_x} + {1'b0, prod.dsq_y};
        in_circle = dsum <= {1'b0, prod.rsq};
        we_next   = prod.pre_pass && (!prod.corner || in_circle);
        addr_next = we_next ? (prod.addr_prod + {{(AW-DW){1'b0}}, prod.xx[DW-1:0]})
                            : '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            we_reg    <= we_next;
            cx_reg    <= prod.xx;
            cy_reg    <= prod.yy;
            addr_reg  <= addr_next;
            color_reg <= prod.color;
        end
    end

    assign write_enable  = we_reg;
    assign canvas_x      = cx_reg;
    assign canvas_y      = cy_reg;
    assign pixel_address = addr_reg;
    assign color_out     = color_reg;

endmodule

// File: src/rounded_rect_pixel_coverage_unit.sv
// ----------------------------------------------------------------------------
// rounded_rect_pixel_coverage_unit
// per-pixel coverage of a rounded rectangle with clipping and address output
//
// usage
//   program the rectangle, radius, outline mode and canvas size over the
//   register port while no transaction is in flight, then offer one offset
//   per cycle on the item channel (item_valid, item_stall)
//   each item gives exactly one result on the result channel
//   (result_valid, result_stall) with write enable, canvas coordinates,
//   linear address and the colour
//   the chain is input register, geometry stage, product stage and result
//   register, so one item is taken every cycle unless the pipeline is
//   full behind a stalled result
//   a stalled result holds; stages behind it keep filling any empty slots
//   and item_stall rises only once every stage holds an item
//   reset clears the configuration registers and the valid flags; the data
//   registers are left as they are
// ----------------------------------------------------------------------------
module rounded_rect_pixel_coverage_unit #(
    parameter int MAX_DIM = rrpc_pkg::MAX_DIM_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rrpc_pkg::PADDR_W-1:0]        paddr,
    input  logic [rrpc_pkg::PDATA_W-1:0]        pwdata,
    output logic [rrpc_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready,

    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic [rrpc_pkg::OFF_W-1:0]          off_x,
    input  logic [rrpc_pkg::OFF_W-1:0]          off_y,
    input  logic [rrpc_pkg::COLOR_W-1:0]        pixel_color,

    output logic                                result_valid,
    input  logic                                result_stall,
    output logic                                write_enable,
    output logic signed [rrpc_pkg::COORD_W-1:0] canvas_x,
    output logic signed [rrpc_pkg::COORD_W-1:0] canvas_y,
    output logic [rrpc_pkg::ADDR_W-1:0]         pixel_address,
    output logic [rrpc_pkg::COLOR_W-1:0]        color_out
);

    localparam int DW = rrpc_pkg::DIM_W;
    localparam int RW = rrpc_pkg::RAD_W;
    localparam int PW = rrpc_pkg::PDATA_W;

    rrpc_pkg::cfg_t     cfg_reg;
    rrpc_pkg::reg_idx_t reg_idx;
    logic               cfg_wr;

    logic [rrpc_pkg::OFF_W-1:0]   offx_reg;
    logic [rrpc_pkg::OFF_W-1:0]   offy_reg;
    logic [rrpc_pkg::COLOR_W-1:0] color_reg;

    logic in_vld_reg;
    logic geom_vld_reg;
    logic prod_vld_reg;
    logic res_vld_reg;

    logic adv_in;
    logic adv_geom;
    logic adv_prod;
    logic adv_res;

    rrpc_pkg::geom_t geom;
    rrpc_pkg::prod_t prod;

    // register port
    assign pready  = 1'b1;
    assign reg_idx = rrpc_pkg::reg_idx_t'(paddr[rrpc_pkg::PADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                rrpc_pkg::REG_RECT_X:       cfg_reg.rect_x       <= pwdata[DW-1:0];
                rrpc_pkg::REG_RECT_Y:       cfg_reg.rect_y       <= pwdata[DW-1:0];
                rrpc_pkg::REG_RECT_W:       cfg_reg.rect_w       <= pwdata[DW-1:0];
                rrpc_pkg::REG_RECT_H:       cfg_reg.rect_h       <= pwdata[DW-1:0];
                rrpc_pkg::REG_RADIUS:       cfg_reg.radius       <= pwdata[RW-1:0];
                rrpc_pkg::REG_OUTLINE_MODE: cfg_reg.outline_mode <= pwdata[0];
                rrpc_pkg::REG_CANVAS_W:     cfg_reg.canvas_w     <= pwdata[DW-1:0];
                rrpc_pkg::REG_CANVAS_H:     cfg_reg.canvas_h     <= pwdata[DW-1:0];
                default:                    cfg_reg              <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            rrpc_pkg::REG_RECT_X:       prdata = {{(PW-DW){1'b0}}, cfg_reg.rect_x};
            rrpc_pkg::REG_RECT_Y:       prdata = {{(PW-DW){1'b0}}, cfg_reg.rect_y};
            rrpc_pkg::REG_RECT_W:       prdata = {{(PW-DW){1'b0}}, cfg_reg.rect_w};
            rrpc_pkg::REG_RECT_H:       prdata = {{(PW-DW){1'b0}}, cfg_reg.rect_h};
            rrpc_pkg::REG_RADIUS:       prdata = {{(PW-RW){1'b0}}, cfg_reg.radius};
            rrpc_pkg::REG_OUTLINE_MODE: prdata = {{(PW-1){1'b0}}, cfg_reg.outline_mode};
            rrpc_pkg::REG_CANVAS_W:     prdata = {{(PW-DW){1'b0}}, cfg_reg.canvas_w};
            rrpc_pkg::REG_CANVAS_H:     prdata = {{(PW-DW){1'b0}}, cfg_reg.canvas_h};
            default:                    prdata = '0;
        endcase
    end

    // pipeline flow, empty stages fill even while the output is stalled
    assign adv_res    = !res_vld_reg || !result_stall;
    assign adv_prod   = !prod_vld_reg || adv_res;
    assign adv_geom   = !geom_vld_reg || adv_prod;
    assign adv_in     = !in_vld_reg || adv_geom;
    assign item_stall = !adv_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg   <= 1'b0;
            geom_vld_reg <= 1'b0;
            prod_vld_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            if (adv_in)
            begin
                in_vld_reg <= item_valid;
            end
            if (adv_geom)
            begin
                geom_vld_reg <= in_vld_reg;
            end
            if (adv_prod)
            begin
                prod_vld_reg <= geom_vld_reg;
            end
            if (adv_res)
            begin
                res_vld_reg <= prod_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_in)
        begin
            offx_reg  <= off_x;
            offy_reg  <= off_y;
            color_reg <= pixel_color;
        end
    end

    rrpc_geom #(
        .MAX_DIM (MAX_DIM)
    ) u_geom (
        .clk   (clk),
        .en    (adv_geom),
        .cfg   (cfg_reg),
        .off_x (offx_reg),
        .off_y (offy_reg),
        .color (color_reg),
        .geom  (geom)
    );

    rrpc_prod u_prod (
        .clk  (clk),
        .en   (adv_prod),
        .geom (geom),
        .prod (prod)
    );

    rrpc_resolve u_resolve (
        .clk           (clk),
        .en            (adv_res),
        .prod          (prod),
        .write_enable  (write_enable),
        .canvas_x      (canvas_x),
        .canvas_y      (canvas_y),
        .pixel_address (pixel_address),
        .color_out     (color_out)
    );

    assign result_valid = res_vld_reg;

endmodule

// File: bench/tb_rounded_rect_pixel_coverage_unit.sv
// ----------------------------------------------------------------------------
// tb_rounded_rect_pixel_coverage_unit
// self-checking bench for the rounded-rectangle pixel coverage unit
//
// programs rectangle, radius, outline mode and canvas size over the register
// port between bursts of pixel offsets, predicts write enable, canvas
// coordinates, linear address and colour for every accepted transaction and
// checks every result in order, under random idling on both channels, one
// long result hold-off and a stretch without random idling at the end
// ----------------------------------------------------------------------------
module tb_rounded_rect_pixel_coverage_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int OFF_W   = rrpc_pkg::OFF_W;
    localparam int COLOR_W = rrpc_pkg::COLOR_W;
    localparam int COORD_W = rrpc_pkg::COORD_W;
    localparam int ADDR_W  = rrpc_pkg::ADDR_W;
    localparam int PADDR_W = rrpc_pkg::PADDR_W;
    localparam int PDATA_W = rrpc_pkg::PDATA_W;
    localparam int DIM_W   = rrpc_pkg::DIM_W;
    localparam int RAD_W   = rrpc_pkg::RAD_W;

    localparam int CLK_HALF    = 4;
    localparam int DIM_LIMIT   = rrpc_pkg::MAX_DIM_DEF;
    localparam int DRAIN_WAIT  = 8;
    localparam int HOLD_CYCLES = 300;
    localparam int STUCK_LIMIT = 2000;

    typedef struct packed {
        logic [OFF_W-1:0]   ox;
        logic [OFF_W-1:0]   oy;
        logic [COLOR_W-1:0] col;
    } pixel_req_t;

    typedef struct packed {
        logic                      we;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic [ADDR_W-1:0]         addr;
        logic [COLOR_W-1:0]        col;
    } pixel_res_t;

    logic                      clk;
    logic                      rst_n;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [PADDR_W-1:0]        paddr;
    logic [PDATA_W-1:0]        pwdata;
    logic [PDATA_W-1:0]        prdata;
    logic                      pready;
    logic                      item_valid;
    logic                      item_stall;
    logic [OFF_W-1:0]          off_x;
    logic [OFF_W-1:0]          off_y;
    logic [COLOR_W-1:0]        pixel_color;
    logic                      result_valid;
    logic                      result_stall;
    logic                      write_enable;
    logic signed [COORD_W-1:0] canvas_x;
    logic signed [COORD_W-1:0] canvas_y;
    logic [ADDR_W-1:0]         pixel_address;
    logic [COLOR_W-1:0]        color_out;

    rrpc_pkg::cfg_t cfg_shadow;
    pixel_req_t     pending_pixels[$];
    pixel_res_t     expected_pixels[$];
    pixel_req_t     next_req;
    pixel_res_t     exp_px;
    bit             item_taken;
    bit             idle_on;
    bit             hold_request;
    bit             busy;
    int             send_gap;
    int             recv_gap;
    int             hold_left;
    int             n_queued;
    int             n_accepted;
    int             stuck_cycles;
    int             fail_count;

    rounded_rect_pixel_coverage_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .off_x         (off_x),
        .off_y         (off_y),
        .pixel_color   (pixel_color),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .write_enable  (write_enable),
        .canvas_x      (canvas_x),
        .canvas_y      (canvas_y),
        .pixel_address (pixel_address),
        .color_out     (color_out)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    function automatic longint sat_dim(logic [DIM_W-1:0] v);
        return (v > DIM_LIMIT) ? longint'(DIM_LIMIT) : longint'(v);
    endfunction

    function automatic pixel_res_t predict_pixel(logic [OFF_W-1:0] ox, logic [OFF_W-1:0] oy,
                                                 logic [COLOR_W-1:0] col);
        longint     dx, dy, w, h, cw, ch, r, xx, yy, ccx, ccy, ex, ey;
        bit         we, lft, tp, rt, bt, corner, ring;
        pixel_res_t res;
        dx = longint'(ox);
        dy = longint'(oy);
        w  = sat_dim(cfg_shadow.rect_w);
        h  = sat_dim(cfg_shadow.rect_h);
        cw = sat_dim(cfg_shadow.canvas_w);
        ch = sat_dim(cfg_shadow.canvas_h);
        r  = longint'(cfg_shadow.radius);
        xx = longint'($signed(cfg_shadow.rect_x)) + dx;
        yy = longint'($signed(cfg_shadow.rect_y)) + dy;
        if (r > w / 2)
            r = w / 2;
        if (r > h / 2)
            r = h / 2;
        we = 1'b1;
        if (dx >= w || dy >= h)
            we = 1'b0;
        if (xx < 0 || xx >= cw || yy < 0 || yy >= ch)
            we = 1'b0;
        lft    = dx < r;
        tp     = dy < r;
        rt     = dx >= w - r;
        bt     = dy >= h - r;
        corner = 1'b1;
        ccx    = 0;
        ccy    = 0;
        if (lft && tp)
        begin
            ccx = r - 1;
            ccy = r - 1;
        end
        else if (rt && tp)
        begin
            ccx = w - r;
            ccy = r - 1;
        end
        else if (lft && bt)
        begin
            ccx = r - 1;
            ccy = h - r;
        end
        else if (rt && bt)
        begin
            ccx = w - r;
            ccy = h - r;
        end
        else
            corner = 1'b0;
        if (we && corner)
        begin
            ex = dx - ccx;
            ey = dy - ccy;
            if (ex * ex + ey * ey > r * r)
                we = 1'b0;
        end
        if (we && cfg_shadow.outline_mode)
        begin
            ring = dx == 0 || dy == 0 || dx == w - 1 || dy == h - 1 ||
                   dx == 1 || dy == 1 || dx == w - 2 || dy == h - 2;
            if (!ring)
                we = 1'b0;
        end
        res.we   = we;
        res.cx   = xx[COORD_W-1:0];
        res.cy   = yy[COORD_W-1:0];
        res.addr = we ? ADDR_W'(yy * cw + xx) : '0;
        res.col  = col;
        return res;
    endfunction

    // item driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!item_valid || item_taken)
            begin
                item_taken = 1'b0;
                if (send_gap == 0 && idle_on && $urandom_range(0, 11) == 0)
                    send_gap = $urandom_range(1, 15);
                if (send_gap != 0)
                begin
                    send_gap--;
                    item_valid <= 1'b0;
                end
                else if (pending_pixels.size() != 0)
                begin
                    next_req = pending_pixels.pop_front();
                    off_x       <= next_req.ox;
                    off_y       <= next_req.oy;
                    pixel_color <= next_req.col;
                    item_valid  <= 1'b1;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // result receiver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else if (recv_gap != 0)
            begin
                recv_gap--;
                result_stall <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 11) == 0)
            begin
                recv_gap = $urandom_range(0, 14);
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    // monitor, checker and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            busy = 1'b0;
            if (item_valid && !item_stall)
            begin
                expected_pixels.push_back(predict_pixel(off_x, off_y, pixel_color));
                item_taken = 1'b1;
                n_accepted++;
                busy = 1'b1;
            end
            if (result_valid && !result_stall)
            begin
                busy = 1'b1;
                if (expected_pixels.size() == 0)
                begin
                    $error("result transaction with no pending prediction");
                    fail_count++;
                end
                else
                begin
                    exp_px = expected_pixels.pop_front();
                    if (write_enable !== exp_px.we)
                    begin
                        $error("write_enable: expected %0d actual %0d", exp_px.we, write_enable);
                        fail_count++;
                    end
                    if (canvas_x !== exp_px.cx)
                    begin
                        $error("canvas_x: expected %0d actual %0d", exp_px.cx, canvas_x);
                        fail_count++;
                    end
                    if (canvas_y !== exp_px.cy)
                    begin
                        $error("canvas_y: expected %0d actual %0d", exp_px.cy, canvas_y);
                        fail_count++;
                    end
                    if (pixel_address !== exp_px.addr)
                    begin
                        $error("pixel_address: expected %0d actual %0d",
                               exp_px.addr, pixel_address);
                        fail_count++;
                    end
                    if (color_out !== exp_px.col)
                    begin
                        $error("color_out: expected %h actual %h", exp_px.col, color_out);
                        fail_count++;
                    end
                end
            end
            stuck_cycles = busy ? 0 : stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic reg_write(rrpc_pkg::reg_idx_t idx, logic [PDATA_W-1:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            rrpc_pkg::REG_RECT_X:       cfg_shadow.rect_x       = val[DIM_W-1:0];
            rrpc_pkg::REG_RECT_Y:       cfg_shadow.rect_y       = val[DIM_W-1:0];
            rrpc_pkg::REG_RECT_W:       cfg_shadow.rect_w       = val[DIM_W-1:0];
            rrpc_pkg::REG_RECT_H:       cfg_shadow.rect_h       = val[DIM_W-1:0];
            rrpc_pkg::REG_RADIUS:       cfg_shadow.radius       = val[RAD_W-1:0];
            rrpc_pkg::REG_OUTLINE_MODE: cfg_shadow.outline_mode = val[0];
            rrpc_pkg::REG_CANVAS_W:     cfg_shadow.canvas_w     = val[DIM_W-1:0];
            rrpc_pkg::REG_CANVAS_H:     cfg_shadow.canvas_h     = val[DIM_W-1:0];
            default:                    ;
        endcase
    endtask

    task automatic program_shape(int x, int y, int w, int h, int r, int mode, int cw, int ch);
        reg_write(rrpc_pkg::REG_RECT_X, PDATA_W'(x));
        reg_write(rrpc_pkg::REG_RECT_Y, PDATA_W'(y));
        reg_write(rrpc_pkg::REG_RECT_W, PDATA_W'(w));
        reg_write(rrpc_pkg::REG_RECT_H, PDATA_W'(h));
        reg_write(rrpc_pkg::REG_RADIUS, PDATA_W'(r));
        reg_write(rrpc_pkg::REG_OUTLINE_MODE, PDATA_W'(mode));
        reg_write(rrpc_pkg::REG_CANVAS_W, PDATA_W'(cw));
        reg_write(rrpc_pkg::REG_CANVAS_H, PDATA_W'(ch));
    endtask

    task automatic queue_pixel(int ox, int oy, logic [COLOR_W-1:0] col);
        pixel_req_t req;
        req.ox  = OFF_W'(ox);
        req.oy  = OFF_W'(oy);
        req.col = col;
        pending_pixels.push_back(req);
        n_queued++;
    endtask

    task automatic queue_random_pixel();
        int lim_x;
        int lim_y;
        lim_x = int'((sat_dim(cfg_shadow.rect_w) + 1 > 2047) ? 2047 :
                     sat_dim(cfg_shadow.rect_w) + 1);
        lim_y = int'((sat_dim(cfg_shadow.rect_h) + 1 > 2047) ? 2047 :
                     sat_dim(cfg_shadow.rect_h) + 1);
        if ($urandom_range(0, 4) == 0)
            queue_pixel($urandom_range(0, 2047), $urandom_range(0, 2047), $urandom);
        else
            queue_pixel($urandom_range(0, lim_x), $urandom_range(0, lim_y), $urandom);
    endtask

    task automatic random_shape();
        int w;
        int h;
        if ($urandom_range(0, 3) == 0)
            program_shape($urandom_range(0, 4095), $urandom_range(0, 4095),
                          $urandom_range(0, 4095), $urandom_range(0, 4095),
                          $urandom_range(0, 2047), $urandom_range(0, 1),
                          $urandom_range(0, 4095), $urandom_range(0, 4095));
        else
        begin
            w = $urandom_range(0, 48);
            h = $urandom_range(0, 48);
            program_shape(int'($urandom_range(0, 80)) - 30, int'($urandom_range(0, 80)) - 30,
                          w, h, $urandom_range(0, 30), $urandom_range(0, 1),
                          $urandom_range(0, 100), $urandom_range(0, 100));
        end
    endtask

    task automatic drain();
        while (n_accepted != n_queued || expected_pixels.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT)
            @(negedge clk);
    endtask

    initial
    begin
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        item_valid   = 1'b0;
        off_x        = '0;
        off_y        = '0;
        pixel_color  = '0;
        result_stall = 1'b0;
        cfg_shadow   = '0;
        item_taken   = 1'b0;
        idle_on      = 1'b1;
        hold_request = 1'b0;
        send_gap     = 0;
        recv_gap     = 0;
        hold_left    = 0;
        n_queued     = 0;
        n_accepted   = 0;
        stuck_cycles = 0;
        fail_count   = 0;
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // filled shape, corner arcs, rectangle bounds, offset extremes
        program_shape(0, 0, 20, 12, 5, 0, 2048, 2048);
        queue_pixel(0, 0, '0);
        queue_pixel(4, 0, $urandom);
        queue_pixel(0, 1, $urandom);
        queue_pixel(1, 1, $urandom);
        queue_pixel(19, 11, $urandom);
        queue_pixel(15, 0, $urandom);
        queue_pixel(10, 6, $urandom);
        queue_pixel(20, 5, $urandom);
        queue_pixel(5, 12, $urandom);
        queue_pixel(2047, 2047, '1);
        queue_pixel(0, 2047, $urandom);
        drain();

        // outline rings with zero radius, left edge off canvas, oversized canvas
        program_shape(-5, 3, 30, 30, 0, 1, 100, 4095);
        queue_pixel(0, 0, $urandom);
        queue_pixel(5, 0, $urandom);
        queue_pixel(7, 10, $urandom);
        queue_pixel(28, 10, $urandom);
        queue_pixel(27, 10, $urandom);
        queue_pixel(29, 29, '1);
        queue_pixel(10, 1, $urandom);
        queue_pixel(6, 28, $urandom);
        drain();

        // thin outline with clamped radius
        program_shape(10, 10, 4, 3, 1024, 1, 64, 64);
        queue_pixel(0, 0, $urandom);
        queue_pixel(1, 1, $urandom);
        queue_pixel(3, 2, $urandom);
        queue_pixel(2, 1, $urandom);
        drain();

        // register extremes with an empty canvas
        program_shape(2047, -2048, 4095, 4095, 2047, 0, 0, 0);
        queue_pixel(0, 2047, $urandom);
        queue_pixel(2047, 0, $urandom);
        drain();

        for (int ph = 0; ph < 14; ph++)
        begin
            if (ph >= 12)
                idle_on = 1'b0;
            random_shape();
            if (ph == 3)
            begin
                @(posedge clk);
                hold_request = 1'b1;
            end
            for (int k = 0; k < 50; k++)
                queue_random_pixel();
            drain();
        end

        if (fail_count == 0 && expected_pixels.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
